/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and gated off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  `ASSERT_ALWAYS(label, clk, rstn, (ante) |=> (cons), msg)

`endif

/* src/u8cp_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 to Windows-1252 transcoder package
// Types, constants and decode helpers shared by the transcoder files.
// ----------------------------------------------------------------------------
package u8cp_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [20:0] cp_t;
  typedef logic [2:0]  seq_len_t;
  typedef logic [1:0]  res_cnt_t;

  // Lead byte classes, given as the sequence length they open.
  localparam seq_len_t LenStray = 3'd0;
  localparam seq_len_t LenOne   = 3'd1;
  localparam seq_len_t LenTwo   = 3'd2;
  localparam seq_len_t LenThree = 3'd3;
  localparam seq_len_t LenFour  = 3'd4;

  localparam byte_t QMark = 8'h3F;

  function automatic seq_len_t lead_len(byte_t b);
    seq_len_t len;
    if (b[7] == 1'b0) begin
      len = LenOne;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = LenTwo;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = LenThree;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = LenFour;
    end else begin
      len = LenStray;
    end
    return len;
  endfunction

  function automatic logic is_ascii(byte_t b);
    return ~b[7];
  endfunction

  // Tail bytes contribute their low six bits whatever their top bits are.
  function automatic cp_t assemble_cp(byte_t b0, byte_t b1, byte_t b2, byte_t b3,
                                      seq_len_t len);
    cp_t cp;
    case (len)
      LenTwo:   cp = {10'd0, b0[4:0], b1[5:0]};
      LenThree: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    return cp;
  endfunction

  function automatic byte_t map_cp(cp_t cp);
    byte_t r;
    if (cp inside {[21'h00:21'h7F], [21'hA0:21'hFF]}) begin
      r = cp[7:0];
    end else begin
      case (cp)
        21'h2013: r = 8'h96;
        21'h2014: r = 8'h97;
        21'h2018: r = 8'h91;
        21'h2019: r = 8'h92;
        21'h201C: r = 8'h93;
        21'h201D: r = 8'h94;
        21'h2022: r = 8'h95;
        21'h2026: r = 8'h85;
        default:  r = QMark;
      endcase
    end
    return r;
  endfunction

endpackage

/* src/utf8_to_cp1252_transcoder_unit.sv */
// ----------------------------------------------------------------------------
// UTF-8 to Windows-1252 transcoder
// Converts a UTF-8 byte stream into single Windows-1252 bytes per code point.
// ----------------------------------------------------------------------------
// The unit takes one UTF-8 byte per cycle on the slave stream while its
// input register can advance, with tlast marking the final byte of a
// string, and emits one Windows-1252 byte for each decoded code point on
// the master stream. A byte passes from the input register to the result
// register, whose slot zero drives the master stream. Sustained throughput
// is one byte per cycle while the master stream is ready; a byte that opens
// or continues a sequence gives no result. The only case that gives more
// than one result is a string that ends inside a multi-byte sequence: the
// lead byte gives '?' and the held bytes are decoded again, for up to three
// results, and the result register drains them at one per cycle while the
// master stream is ready, holding the input until the last one leaves.
// Tail bytes are not checked to be continuation bytes. Code points 0x00-0x7F
// and 0xA0-0xFF pass through, eight typographic marks map to 0x85 and
// 0x91-0x97, and everything else, including stray bytes, gives '?'.
module utf8_to_cp1252_transcoder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
  input  logic              s_axis_tlast,   // string_end
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tuser,   // [0] run_last
  output logic              m_axis_tlast    // string_done
);
  import u8cp_pkg::*;

  // Input register.
  logic     in_valid_q;
  byte_t    in_byte_q;
  logic     in_last_q;
  logic     in_adv;

  // Open sequence state.
  byte_t    held_q [3];
  byte_t    held_d [3];
  res_cnt_t held_cnt_q, held_cnt_d;
  seq_len_t need_q, need_d;

  // Decode results of the item in the input register.
  byte_t    res [3];
  res_cnt_t res_cnt;

  // Result register: up to three bytes drained from slot zero.
  byte_t    out_q [3];
  res_cnt_t out_cnt_q;
  logic     out_done_q;
  logic     out_xfer;
  logic     out_free;

  byte_t    buf_b [4];
  seq_len_t n_len;
  seq_len_t tail_len;

  assign out_xfer = m_axis_tvalid & m_axis_tready;
  // The result register can take a new group when it is empty or its last
  // byte leaves in this cycle.
  assign out_free = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && m_axis_tready);
  assign in_adv   = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | in_adv;

  always_comb begin
    // Bytes of the sequence as it would stand with the new byte appended.
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < held_cnt_q) begin
        buf_b[k] = held_q[k];
      end else if (2'(k) == held_cnt_q) begin
        buf_b[k] = in_byte_q;
      end else begin
        buf_b[k] = 8'h00;
      end
    end
    buf_b[3] = in_byte_q;
    n_len    = {1'b0, held_cnt_q} + 3'd1;
    tail_len = lead_len(held_q[1]);

    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    need_d     = need_q;
    res[0]     = QMark;
    res[1]     = QMark;
    res[2]     = QMark;
    res_cnt    = 2'd0;

    if (held_cnt_q == 2'd0) begin
      if (lead_len(in_byte_q) == LenOne) begin
        res[0]  = in_byte_q;
        res_cnt = 2'd1;
      end else if ((lead_len(in_byte_q) == LenStray) || in_last_q) begin
        res_cnt = 2'd1;
      end else begin
        held_d[0]  = in_byte_q;
        held_cnt_d = 2'd1;
        need_d     = lead_len(in_byte_q);
      end
    end else if ((n_len == need_q) || (n_len == LenFour)) begin
      res[0]     = map_cp(assemble_cp(buf_b[0], buf_b[1], buf_b[2], buf_b[3], n_len));
      res_cnt    = 2'd1;
      held_cnt_d = 2'd0;
      need_d     = LenStray;
    end else if (in_last_q) begin
      // Truncated string: the lead gives '?', then the rest is decoded as a
      // complete short string.
      held_cnt_d = 2'd0;
      need_d     = LenStray;
      if (held_cnt_q == 2'd1) begin
        res[1]  = is_ascii(in_byte_q) ? in_byte_q : QMark;
        res_cnt = 2'd2;
      end else if (tail_len == LenTwo) begin
        res[1]  = map_cp(assemble_cp(held_q[1], in_byte_q, 8'h00, 8'h00, LenTwo));
        res_cnt = 2'd2;
      end else begin
        res[1]  = (tail_len == LenOne) ? held_q[1] : QMark;
        res[2]  = is_ascii(in_byte_q) ? in_byte_q : QMark;
        res_cnt = 2'd3;
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) == held_cnt_q) begin
          held_d[k] = in_byte_q;
        end
      end
      held_cnt_d = n_len[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      held_cnt_q <= 2'd0;
      need_q     <= LenStray;
      out_cnt_q  <= 2'd0;
      out_done_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (in_adv) begin
        held_cnt_q <= held_cnt_d;
        need_q     <= need_d;
      end
      if (in_adv && (res_cnt != 2'd0)) begin
        out_cnt_q  <= res_cnt;
        out_done_q <= in_last_q;
      end else if (out_xfer) begin
        out_cnt_q  <= out_cnt_q - 2'd1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (in_adv) begin
      held_q <= held_d;
    end
    if (in_adv && (res_cnt != 2'd0)) begin
      out_q <= res;
    end else if (out_xfer) begin
      out_q[0] <= out_q[1];
      out_q[1] <= out_q[2];
    end
  end

  assign m_axis_tvalid = (out_cnt_q != 2'd0);
  assign m_axis_tdata  = out_q[0];
  assign m_axis_tuser  = (out_cnt_q == 2'd1);
  assign m_axis_tlast  = (out_cnt_q == 2'd1) & out_done_q;

endmodule

/* src/u8cp_checker.sv */
// ----------------------------------------------------------------------------
// UTF-8 to Windows-1252 transcoder checker
// Port-level assertions on the transcoder's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8cp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled result keeps its data and flags.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}),
               "result changed while stalled")

  // The end of a string is always the last result of its byte.
  `ASSERT_ALWAYS(a_done_is_last, clk_i, rst_ni, (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser,
                 "string end on a result that is not last for its byte")

  // Results of one byte follow each other without a gap.
  `ASSERT_NEXT(a_group_cont, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tuser,
               m_axis_tvalid, "result group broken")

  // With the result register empty, the input side is always ready.
  `ASSERT_ALWAYS(a_empty_ready, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready,
                 "input not ready while no result is pending")

endmodule

bind utf8_to_cp1252_transcoder_unit u8cp_checker u_checker (.*);
